>>> rtl/core/bmr_pkg.sv
// constants and types shared by the b-matrix rotation pipeline
package bmr_pkg;

   localparam int TERM_W  = 32;
   localparam int ROT_W   = 16;
   localparam int ROW_W   = 3 * ROT_W;
   localparam int NUM_OUT = 6;
   localparam int DATA_W  = NUM_OUT * TERM_W;
   localparam int D_W     = TERM_W + 1;
   localparam int P1_W    = D_W + ROT_W;
   localparam int T_W     = P1_W + 2;
   localparam int HI_W    = T_W - 32;
   localparam int PHI_W   = HI_W + ROT_W;
   localparam int PLO_W   = 33 + ROT_W;
   localparam int SHI_W   = PHI_W + 2;
   localparam int SLO_W   = PLO_W + 2;
   localparam int S_W     = SHI_W + 32;
   localparam int IDX_W   = 2;

   localparam int DIAG_SHIFT = 29;
   localparam int OFF_SHIFT  = 28;

   typedef logic [IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_ROT_ROW0 = 2'd0;
   localparam csr_index_type CSR_ROT_ROW1 = 2'd1;
   localparam csr_index_type CSR_ROT_ROW2 = 2'd2;

   localparam logic [ROW_W-1:0] ROT_ROW0_RESET = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROT_ROW2_RESET = 48'h4000_0000_0000;

   typedef logic signed [ROT_W-1:0] rot_type;
   typedef logic signed [D_W-1:0]   d_type;
   typedef logic signed [P1_W-1:0]  p1_type;
   typedef logic signed [T_W-1:0]   t_type;
   typedef logic signed [PHI_W-1:0] phi_type;
   typedef logic signed [PLO_W-1:0] plo_type;
   typedef logic signed [S_W-1:0]   s_type;

   localparam s_type RND_DIAG = s_type'(1) <<< (DIAG_SHIFT - 1);
   localparam s_type RND_OFF  = s_type'(1) <<< (OFF_SHIFT - 1);
   localparam s_type SAT_MAX  = s_type'(2147483647);
   localparam s_type SAT_MIN  = -(s_type'(1) <<< 31);

   // matrix position of each result term: xx, xy, xz, yy, yz, zz
   localparam int OUT_I [NUM_OUT] = '{0, 0, 0, 1, 1, 2};
   localparam int OUT_J [NUM_OUT] = '{0, 1, 2, 1, 2, 2};

endpackage

>>> rtl/core/bmatrix_rotate.sv
// b-matrix row rotation R^T B R, five-stage pipeline
// Takes one six-term B-matrix row per transfer and returns the six terms of R^T B R,
// off-diagonals doubled, rounded to nearest (ties up) and saturated to 32 bits. One
// item enters every cycle while the result stream is not stalled; each item passes
// through the register stages in order: D*R products, row sums, R^T*T partial
// products, exact 69-bit sums, round and saturate. Each stage holds its item while
// the stage behind it is full, so a stalled result stream loses nothing. The rotation
// rows are written through the csr port by the user only between runs; the block
// itself does not enforce this. The rows reset to the identity.
module bmatrix_rotate
   import bmr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // b_xx, b_xy_twice, b_xz_twice, b_yy, b_yz_twice, b_zz
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,
   // r_xx, r_xy_twice, r_xz_twice, r_yy, r_yz_twice, r_zz
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,
   input  logic                csr_wr_en,
   input  csr_index_type       csr_index,
   input  logic [ROW_W-1:0]    csr_wdata
);

   logic [ROW_W-1:0] rot_row_ff [3];
   rot_type          r [3][3];

   logic [5:1] v_ff;
   logic [5:1] rdy;

   p1_type  p1_ff  [3][3][3];
   p1_type  p1_in  [3][3][3];
   t_type   t_ff   [3][3];
   t_type   t_in   [3][3];
   phi_type phi_ff [NUM_OUT][3];
   phi_type phi_in [NUM_OUT][3];
   plo_type plo_ff [NUM_OUT][3];
   plo_type plo_in [NUM_OUT][3];
   s_type   s_ff   [NUM_OUT];
   s_type   s_in   [NUM_OUT];
   logic [TERM_W-1:0] out_ff [NUM_OUT];
   logic [TERM_W-1:0] out_in [NUM_OUT];

   d_type   d [3][3];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= ROT_ROW0_RESET;
         rot_row_ff[1] <= ROT_ROW1_RESET;
         rot_row_ff[2] <= ROT_ROW2_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROT_ROW0: rot_row_ff[0] <= csr_wdata;
            CSR_ROT_ROW1: rot_row_ff[1] <= csr_wdata;
            CSR_ROT_ROW2: rot_row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            r[a][b] = rot_type'(rot_row_ff[a][ROT_W*b +: ROT_W]);
         end
      end
   end

   // stage ready chain, a stage loads when empty or when it drains forward
   always_comb begin
      rdy[5] = !v_ff[5] || rsp_tready;
      for (int k = 4; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) v_ff[1] <= req_tvalid;
         for (int k = 2; k <= 5; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // rebuild D = 2B from the row
   always_comb begin
      d[0][0] = d_type'({req_tdata[0*TERM_W +: TERM_W], 1'b0});
      d[0][1] = d_type'($signed(req_tdata[1*TERM_W +: TERM_W]));
      d[0][2] = d_type'($signed(req_tdata[2*TERM_W +: TERM_W]));
      d[1][1] = d_type'({req_tdata[3*TERM_W +: TERM_W], 1'b0});
      d[1][2] = d_type'($signed(req_tdata[4*TERM_W +: TERM_W]));
      d[2][2] = d_type'({req_tdata[5*TERM_W +: TERM_W], 1'b0});
      d[1][0] = d[0][1];
      d[2][0] = d[0][2];
      d[2][1] = d[1][2];
   end

   // stage 1: products of D*R
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            for (int c = 0; c < 3; c++) begin
               p1_in[a][b][c] = d[a][c] * r[c][b];
            end
         end
      end
   end

   // stage 2: T = D*R
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            t_in[a][b] = t_type'(p1_ff[a][b][0]) + t_type'(p1_ff[a][b][1])
                       + t_type'(p1_ff[a][b][2]);
         end
      end
   end

   // stage 3: R^T*T partial products, T split into signed high and unsigned low words
   always_comb begin
      for (int n = 0; n < NUM_OUT; n++) begin
         for (int c = 0; c < 3; c++) begin
            phi_in[n][c] = r[c][OUT_I[n]] * $signed(t_ff[c][OUT_J[n]][T_W-1:32]);
            plo_in[n][c] = r[c][OUT_I[n]] * $signed({1'b0, t_ff[c][OUT_J[n]][31:0]});
         end
      end
   end

   // stage 4: exact sum in units of 2^-28 of D (2^-29 of B)
   always_comb begin
      logic signed [SHI_W-1:0] shi;
      logic signed [SLO_W-1:0] slo;
      for (int n = 0; n < NUM_OUT; n++) begin
         shi = SHI_W'(phi_ff[n][0]) + SHI_W'(phi_ff[n][1]) + SHI_W'(phi_ff[n][2]);
         slo = SLO_W'(plo_ff[n][0]) + SLO_W'(plo_ff[n][1]) + SLO_W'(plo_ff[n][2]);
         s_in[n] = $signed({shi, 32'b0}) + s_type'(slo);
      end
   end

   // stage 5: round half up, then saturate
   always_comb begin
      s_type q;
      for (int n = 0; n < NUM_OUT; n++) begin
         if (OUT_I[n] == OUT_J[n]) begin
            q = (s_ff[n] + RND_DIAG) >>> DIAG_SHIFT;
         end else begin
            q = (s_ff[n] + RND_OFF) >>> OFF_SHIFT;
         end
         if (q > SAT_MAX) begin
            out_in[n] = TERM_W'(SAT_MAX);
         end else if (q < SAT_MIN) begin
            out_in[n] = TERM_W'(SAT_MIN);
         end else begin
            out_in[n] = q[TERM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) p1_ff  <= p1_in;
      if (rdy[2]) t_ff   <= t_in;
      if (rdy[3]) begin
         phi_ff <= phi_in;
         plo_ff <= plo_in;
      end
      if (rdy[4]) s_ff   <= s_in;
      if (rdy[5]) out_ff <= out_in;
   end

   assign rsp_tvalid = v_ff[5];

   always_comb begin
      for (int n = 0; n < NUM_OUT; n++) begin
         rsp_tdata[n*TERM_W +: TERM_W] = out_ff[n];
      end
   end

endmodule
